// ===== sv/wht_pkg.sv =====
// Shared types, constants and the arctangent table of the waypoint heading tracker.
// Used by the front end, the back end and the top level; depends on nothing.
package wht_pkg;

  localparam int TABLE_DEPTH_DEF  = 256;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [14:0] MAX_SPEED_RST = 15'd2048;
  localparam logic [15:0] POS_TOL_RST   = 16'd82;

  localparam logic signed [23:0] ANG_PI_Q20      = 24'sd3294199;
  localparam logic signed [23:0] ANG_HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [16:0] ANG_PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] ANG_TWO_PI_Q12  = 17'sd25736;

  localparam logic REG_MAX_SPEED = 1'b0;
  localparam logic REG_POS_TOL   = 1'b1;

  typedef enum logic [2:0] {
    MODE_POSE    = 3'd0,
    MODE_APPEND  = 3'd1,
    MODE_CLEAR   = 3'd2,
    MODE_START   = 3'd3,
    MODE_STOP    = 3'd4,
    MODE_PROCEED = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_POSE,
    CMD_APPEND,
    CMD_CLEAR,
    CMD_START,
    CMD_STOP,
    CMD_PROCEED
  } cmd_t;

  // Pose words carry position and heading, append words carry the waypoint.
  typedef struct packed {
    cmd_t               cmd;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] v;
  } item_t;

  function automatic logic signed [23:0] atan_q20(input logic [4:0] i);
    logic signed [23:0] r;
    unique case (i)
      5'd0:    r = 24'sd823550;
      5'd1:    r = 24'sd486170;
      5'd2:    r = 24'sd256879;
      5'd3:    r = 24'sd130396;
      5'd4:    r = 24'sd65451;
      5'd5:    r = 24'sd32757;
      5'd6:    r = 24'sd16383;
      5'd7:    r = 24'sd8192;
      5'd8:    r = 24'sd4096;
      5'd9:    r = 24'sd2048;
      5'd10:   r = 24'sd1024;
      5'd11:   r = 24'sd512;
      5'd12:   r = 24'sd256;
      5'd13:   r = 24'sd128;
      5'd14:   r = 24'sd64;
      5'd15:   r = 24'sd32;
      5'd16:   r = 24'sd16;
      5'd17:   r = 24'sd8;
      5'd18:   r = 24'sd4;
      5'd19:   r = 24'sd2;
      5'd20:   r = 24'sd1;
      default: r = 24'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/wht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module wht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/wht_front.sv =====
// Front end: accepts input words, classifies the mode and queues the words.
// Depends on wht_pkg.
module wht_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          mode,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic signed [14:0]  heading,
  input  logic signed [23:0]  wp_x,
  input  logic signed [23:0]  wp_y,
  input  logic signed [15:0]  wp_speed,
  output logic                q_valid,
  output wht_pkg::item_t      q_item,
  input  logic                q_pop
);

  localparam int PW = $clog2(wht_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(wht_pkg::QUEUE_DEPTH + 1);

  wht_pkg::item_t q [wht_pkg::QUEUE_DEPTH];
  wht_pkg::item_t item;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           push;

  always_comb begin
    item = '{cmd: wht_pkg::CMD_NOP, x: wp_x, y: wp_y, v: wp_speed};
    unique case (mode)
      wht_pkg::MODE_POSE: begin
        item.cmd = wht_pkg::CMD_POSE;
        item.x   = pos_x;
        item.y   = pos_y;
        item.v   = 16'(heading);
      end
      wht_pkg::MODE_APPEND:  item.cmd = wht_pkg::CMD_APPEND;
      wht_pkg::MODE_CLEAR:   item.cmd = wht_pkg::CMD_CLEAR;
      wht_pkg::MODE_START:   item.cmd = wht_pkg::CMD_START;
      wht_pkg::MODE_STOP:    item.cmd = wht_pkg::CMD_STOP;
      wht_pkg::MODE_PROCEED: item.cmd = wht_pkg::CMD_PROCEED;
      default:               item.cmd = wht_pkg::CMD_NOP;
    endcase
  end

  assign in_stall = (fill == CW'(wht_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(wht_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(wht_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(q_pop);
    end
  end

endmodule

// ===== sv/wht_back.sv =====
// Back end: waypoint table, sequencer, shared CORDIC stage and wheel speed limiting.
// Depends on wht_pkg and wht_ram.
module wht_back #(
  parameter int TABLE_DEPTH  = wht_pkg::TABLE_DEPTH_DEF,
  parameter int CORDIC_STEPS = wht_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  input  wht_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] wheel_a_speed,
  output logic signed [16:0] wheel_b_speed,
  output logic               running,
  output logic [8:0]         target_index
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = $clog2(CORDIC_STEPS);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CMP  = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_CORD = 7'b0001000,
    ST_FIN  = 7'b0010000,
    ST_LIM  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               active;
  logic [14:0]        max_speed;
  logic [15:0]        pos_tol;
  logic signed [23:0] px;
  logic signed [23:0] py;
  logic signed [14:0] hd;
  logic signed [15:0] trans;
  logic signed [27:0] cx;
  logic signed [27:0] cy;
  logic signed [23:0] cz;
  logic [SW-1:0]      step;
  logic signed [16:0] err;
  logic signed [16:0] wa;
  logic signed [16:0] wb;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [63:0]        ram_rdata;
  logic [63:0]        ram_wdata;
  logic [CW-1:0]      idx_inc;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [24:0] adx;
  logic signed [24:0] ady;
  logic               reached;
  logic               take;
  logic signed [27:0] xs;
  logic signed [27:0] ys;
  logic signed [23:0] zc;
  logic signed [23:0] zr;
  logic signed [16:0] e0;
  logic signed [16:0] e1;
  logic signed [18:0] msx;
  logic signed [18:0] rot;
  logic signed [18:0] tr;
  logic signed [18:0] sum;
  logic signed [18:0] dif;
  logic signed [18:0] tl;

  assign take      = (state == ST_IDLE) && q_valid && !out_valid;
  assign q_pop     = take;
  assign idx_inc   = idx + 1'b1;
  assign ram_wdata = {q_item.v, q_item.y, q_item.x};
  assign ram_we    = take && (q_item.cmd == wht_pkg::CMD_APPEND) &&
                     (count < CW'(TABLE_DEPTH));
  assign ram_re    = (take && (q_item.cmd == wht_pkg::CMD_POSE)) ||
                     ((state == ST_CMP) && reached);
  assign ram_raddr = (state == ST_CMP) ? idx_inc[AW-1:0] : idx[AW-1:0];

  wht_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    dx      = 25'(signed'(ram_rdata[23:0])) - 25'(px);
    dy      = 25'(signed'(ram_rdata[47:24])) - 25'(py);
    adx     = dx[24] ? -dx : dx;
    ady     = dy[24] ? -dy : dy;
    reached = (adx <= $signed({9'd0, pos_tol})) && (ady <= $signed({9'd0, pos_tol}));
    xs      = cx >>> step;
    ys      = cy >>> step;
  end

  always_comb begin
    if (cz > wht_pkg::ANG_PI_Q20) begin
      zc = wht_pkg::ANG_PI_Q20;
    end else if (cz < -wht_pkg::ANG_PI_Q20) begin
      zc = -wht_pkg::ANG_PI_Q20;
    end else begin
      zc = cz;
    end
    zr = (zc + 24'sd128) >>> 8;
    e0 = 17'(zr) - 17'(hd);
    if (e0 <= -wht_pkg::ANG_PI_Q12) begin
      e1 = e0 + wht_pkg::ANG_TWO_PI_Q12;
    end else if (e0 > wht_pkg::ANG_PI_Q12) begin
      e1 = e0 - wht_pkg::ANG_TWO_PI_Q12;
    end else begin
      e1 = e0;
    end
  end

  always_comb begin
    msx = $signed({4'd0, max_speed});
    rot = 19'(err) <<< 1;
    if (rot > msx) begin
      rot = msx;
    end else if (rot < -msx) begin
      rot = -msx;
    end
    tr  = 19'(trans);
    sum = rot + tr;
    dif = tr - rot;
    tl  = tr;
    if ((rot > 0 && tr > 0) || (rot < 0 && tr < 0)) begin
      if (sum > msx) begin
        tl = msx - rot;
      end else if (sum < -msx) begin
        tl = -msx - rot;
      end
    end else if ((rot > 0 && tr < 0) || (rot < 0 && tr > 0)) begin
      if (dif > msx) begin
        tl = msx + rot;
      end else if (dif < -msx) begin
        tl = -msx + rot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      active    <= 1'b0;
      max_speed <= wht_pkg::MAX_SPEED_RST;
      pos_tol   <= wht_pkg::POS_TOL_RST;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          wht_pkg::REG_MAX_SPEED: max_speed <= cfg_data[14:0];
          wht_pkg::REG_POS_TOL:   pos_tol   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            wa    <= '0;
            wb    <= '0;
            px    <= q_item.x;
            py    <= q_item.y;
            hd    <= q_item.v[14:0];
            state <= ST_EMIT;
            unique case (q_item.cmd)
              wht_pkg::CMD_POSE: begin
                if (active) begin
                  if (idx >= count) begin
                    active <= 1'b0;
                  end else begin
                    state <= ST_CMP;
                  end
                end
              end
              wht_pkg::CMD_APPEND: begin
                if (ram_we) begin
                  count <= count + 1'b1;
                end
              end
              wht_pkg::CMD_CLEAR: begin
                count  <= '0;
                idx    <= '0;
                active <= 1'b0;
              end
              wht_pkg::CMD_START: begin
                idx    <= '0;
                active <= 1'b1;
              end
              wht_pkg::CMD_STOP:    active <= 1'b0;
              wht_pkg::CMD_PROCEED: active <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_CMP: begin
          if (reached) begin
            idx <= idx_inc;
            if (idx_inc >= count) begin
              active <= 1'b0;
              state  <= ST_EMIT;
            end else begin
              state <= ST_LOAD;
            end
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          trans <= ram_rdata[63:48];
          step  <= '0;
          state <= ST_CORD;
          if (dx == '0 && dy == '0) begin
            cx    <= '0;
            cy    <= '0;
            cz    <= '0;
            state <= ST_FIN;
          end else if (dx < 0) begin
            if (dy >= 0) begin
              cx <= 28'(dy);
              cy <= -28'(dx);
              cz <= wht_pkg::ANG_HALF_PI_Q20;
            end else begin
              cx <= -28'(dy);
              cy <= 28'(dx);
              cz <= -wht_pkg::ANG_HALF_PI_Q20;
            end
          end else begin
            cx <= 28'(dx);
            cy <= 28'(dy);
            cz <= '0;
          end
        end
        ST_CORD: begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + wht_pkg::atan_q20(5'(step));
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - wht_pkg::atan_q20(5'(step));
          end
          step <= step + 1'b1;
          if (step == SW'(CORDIC_STEPS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          err   <= e1;
          state <= ST_LIM;
        end
        ST_LIM: begin
          wa    <= 17'(tl + rot);
          wb    <= 17'(tl - rot);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          out_valid     <= 1'b1;
          wheel_a_speed <= wa;
          wheel_b_speed <= wb;
          running       <= active;
          target_index  <= 9'(idx);
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idx_in_table: assert property (@(posedge clk) disable iff (rst) idx <= count)
    else $error("current index beyond waypoint count");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("waypoint count beyond table depth");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> !out_valid)
    else $error("result overwritten before it was taken");
  a_cordic_active: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORD |-> active)
    else $error("bearing computed while not running");

endmodule

// ===== sv/waypoint_heading_tracker.sv =====
// Sequence: a control word, or a pose sample while stopped, goes from ST_IDLE straight to
// ST_EMIT; a pose sample that finds its path finished ends in ST_EMIT from ST_IDLE or ST_CMP,
// one standing exactly on its waypoint passes ST_CMP, ST_LOAD, ST_FIN and ST_LIM, and one
// that steers also passes the CORDIC stage, which iterates once per cycle, before ST_FIN.
// The back end handles one word at a time and takes no new word until its result is taken;
// the two-word input queue accepts until full. Reset clears count, index, running flag and registers.
module waypoint_heading_tracker #(
  parameter int TABLE_DEPTH  = wht_pkg::TABLE_DEPTH_DEF,
  parameter int CORDIC_STEPS = wht_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic signed [23:0] wp_x,
  input  logic signed [23:0] wp_y,
  input  logic signed [15:0] wp_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] wheel_a_speed,
  output logic signed [16:0] wheel_b_speed,
  output logic               running,
  output logic [8:0]         target_index
);

  logic           q_valid;
  logic           q_pop;
  wht_pkg::item_t q_item;

  wht_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .heading  (heading),
    .wp_x     (wp_x),
    .wp_y     (wp_y),
    .wp_speed (wp_speed),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  wht_back #(.TABLE_DEPTH(TABLE_DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .wheel_a_speed (wheel_a_speed),
    .wheel_b_speed (wheel_b_speed),
    .running       (running),
    .target_index  (target_index)
  );

endmodule
